/* rtl/core/cpf_pkg.sv */
// cpf_pkg: shared constants, codes, command/status structs and the type-length table
// for the packet framer; no dependencies
`default_nettype none

package cpf_pkg;

  // largest packet the store holds
  localparam int MAX_PACKET = 20;
  localparam int IDX_W      = $clog2(MAX_PACKET);
  localparam int LEN_W      = $clog2(MAX_PACKET + 1);

  // fixed field widths of the channels
  localparam int BYTE_W     = 8;
  localparam int OUT_IDX_W  = 5;
  localparam int OUT_LEN_W  = 5;
  localparam int STATUS_W   = 2;
  localparam int TIMEOUT_W  = 16;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [BYTE_W-1:0] START_MARK = 8'h21;
  localparam logic [BYTE_W-1:0] TYPE_A     = 8'h41;
  localparam logic [BYTE_W-1:0] TYPE_B     = 8'h42;
  localparam logic [BYTE_W-1:0] TYPE_C     = 8'h43;
  localparam logic [BYTE_W-1:0] TYPE_G     = 8'h47;
  localparam logic [BYTE_W-1:0] TYPE_L     = 8'h4C;
  localparam logic [BYTE_W-1:0] TYPE_M     = 8'h4D;
  localparam logic [BYTE_W-1:0] TYPE_Q     = 8'h51;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_START = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1;

  // controller to datapath
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic start;    // rewind readout to index 0
    logic advance;  // step readout to the next byte
    logic clear;    // packet finished, drop it
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_now;  // the offered request closes the open packet
    logic reject;     // closed packet failed its checks
    logic last_out;   // readout sits on the final byte
  } dp_stat_t;

  // required length for a type byte, zero when the type has none
  function automatic logic [LEN_W-1:0] type_length(input logic [BYTE_W-1:0] t);
    logic [LEN_W-1:0] len;
    len = '0;
    unique case (t)
      TYPE_A, TYPE_G, TYPE_M, TYPE_L: len = LEN_W'(15);
      TYPE_Q:                         len = LEN_W'(19);
      TYPE_B:                         len = LEN_W'(5);
      TYPE_C:                         len = LEN_W'(6);
      default:                        len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cpf_if.sv */
// cpf_if: handshake channel interfaces for the packet framer
// depends on cpf_pkg
`default_nettype none

interface cpf_item_if import cpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface cpf_result_if import cpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    out_byte;
  logic [OUT_IDX_W-1:0] byte_index;
  logic [OUT_LEN_W-1:0] packet_length;
  logic [STATUS_W-1:0]  status;
  logic                 last;

  modport source (output valid, out_byte, byte_index, packet_length, status, last,
                  input ready);
  modport sink   (input valid, out_byte, byte_index, packet_length, status, last,
                  output ready);
endinterface

interface cpf_cfg_if import cpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/cpf_ctrl.sv */
// cpf_ctrl: sequencing state machine of the packet framer
// depends on cpf_pkg
`default_nettype none

module cpf_ctrl import cpf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  output logic          result_valid,
  input  wire logic     result_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;
  localparam logic [1:0] S_REJECT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (stat.close_now) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // read of byte 0 goes out here, verdict already settled
        cmd.start  = 1'b1;
        state_next = stat.reject ? S_REJECT : S_EMIT;
      end
      S_EMIT: begin
        result_valid = 1'b1;
        if (result_ready) begin
          if (stat.last_out) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_REJECT: begin
        result_valid = 1'b1;
        if (result_ready) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cpf_dp.sv */
// cpf_dp: packet store, counters, checksum check and readout of the packet framer
// depends on cpf_pkg
`default_nettype none

module cpf_dp import cpf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic                 kind,
  input  wire logic [BYTE_W-1:0]    rx_byte,
  input  wire logic                 cfg_we,
  input  wire logic [TIMEOUT_W-1:0] cfg_data,
  output logic [BYTE_W-1:0]         out_byte,
  output logic [OUT_IDX_W-1:0]      byte_index,
  output logic [OUT_LEN_W-1:0]      packet_length,
  output logic [STATUS_W-1:0]       status,
  output logic                      last
);

  logic [BYTE_W-1:0]    mem [MAX_PACKET];
  logic [BYTE_W-1:0]    rd_data;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     rd_addr;

  logic [LEN_W-1:0]     fill;
  logic [BYTE_W-1:0]    sum;
  logic [TIMEOUT_W-1:0] idle;
  logic [TIMEOUT_W-1:0] timeout;
  logic [BYTE_W-1:0]    head_byte;
  logic [BYTE_W-1:0]    type_byte;
  logic [BYTE_W-1:0]    last_byte;

  logic                 is_tick;
  logic                 is_start;
  logic [LEN_W-1:0]     fill_base;
  logic [LEN_W-1:0]     fill_next;
  logic [BYTE_W-1:0]    sum_next;
  logic [TIMEOUT_W-1:0] idle_next;
  logic [BYTE_W-1:0]    type_sel;
  logic [LEN_W-1:0]     need;
  logic                 byte_close;
  logic                 tick_close;
  logic [BYTE_W-1:0]    sum_before;
  logic [STATUS_W-1:0]  verdict;

  assign is_tick   = (kind == KIND_TICK);
  assign is_start  = (rx_byte == START_MARK);
  assign fill_base = is_start ? '0 : fill;
  assign fill_next = fill_base + LEN_W'(1);
  assign sum_next  = (is_start ? '0 : sum) + rx_byte;
  assign idle_next = (idle != '1) ? idle + TIMEOUT_W'(1) : idle;
  // type byte is the incoming one when it lands at index 1
  assign type_sel  = (fill_base == LEN_W'(1)) ? rx_byte : type_byte;
  assign need      = type_length(type_sel);

  assign byte_close = (fill_next >= LEN_W'(MAX_PACKET)) ||
                      ((fill_next >= LEN_W'(2)) && (need != '0) && (fill_next == need));
  assign tick_close = (fill != '0) && (idle_next >= timeout);

  // checksum: last byte is the inverse of the sum of the ones before it
  assign sum_before = sum - last_byte;
  always_comb begin
    if (head_byte != START_MARK) begin
      verdict = ST_NO_START;
    end else if (~sum_before != last_byte) begin
      verdict = ST_BAD_SUM;
    end else begin
      verdict = ST_OK;
    end
  end

  assign stat.close_now = is_tick ? tick_close : byte_close;
  assign stat.reject    = (verdict != ST_OK);
  assign stat.last_out  = ((LEN_W'(idx) + LEN_W'(1)) == fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      sum     <= '0;
      idle    <= '0;
      timeout <= TIMEOUT_RESET;
    end else begin
      if (cfg_we) timeout <= cfg_data;
      if (cmd.clear) begin
        fill <= '0;
        sum  <= '0;
        idle <= '0;
      end else if (cmd.accept) begin
        if (is_tick) begin
          if (fill != '0) idle <= idle_next;
        end else begin
          fill <= fill_next;
          sum  <= sum_next;
          idle <= '0;
        end
      end
    end
  end

  // header bytes kept beside the store
  always_ff @(posedge clk) begin
    if (cmd.accept && !is_tick) begin
      last_byte <= rx_byte;
      if (fill_base == '0)       head_byte <= rx_byte;
      if (fill_base == LEN_W'(1)) type_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !is_tick) begin
      mem[fill_base[IDX_W-1:0]] <= rx_byte;
    end
  end

  // readout: rd_data is a registered read of the entry that idx points at
  always_comb begin
    if (cmd.start) begin
      rd_addr = '0;
    end else if (cmd.advance) begin
      rd_addr = idx + IDX_W'(1);
    end else begin
      rd_addr = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign out_byte      = stat.reject ? '0 : rd_data;
  assign byte_index    = stat.reject ? '0 : OUT_IDX_W'(idx);
  assign packet_length = OUT_LEN_W'(fill);
  assign status        = verdict;
  assign last          = stat.reject || stat.last_out;

endmodule

`default_nettype wire

/* rtl/core/controller_packet_framer_top.sv */
// controller_packet_framer_top: bang-framed packet receiver with inverted-sum checksum
// depends on cpf_pkg, cpf_if, cpf_ctrl, cpf_dp
//
//   channel  | dir | payload                                           | taken when
//   ---------+-----+---------------------------------------------------+-------------------
//   item     | in  | kind, rx_byte                                     | valid && ready
//   result   | out | out_byte, byte_index, packet_length, status, last | valid && ready
//   cfg      | in  | data (idle timeout, 16 bits)                      | valid && ready
//
// a request that leaves the packet open leaves item ready high
// a closing request goes through accept, then verdict and read of byte 0, then n results
//   (packet length, or 1 on rejection), one a cycle while the receiver is ready, from the
//   single read port of the packet store
// synchronous reset clears counters and sum, loads timeout 1; the store is not cleared
// item ready is low from a closing accept until the last result is taken
// cfg is always ready
`default_nettype none

module controller_packet_framer_top import cpf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  cpf_item_if.sink   item,
  cpf_result_if.source result,
  cpf_cfg_if.sink    cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     item_ready;
  logic     result_valid;

  // controller: owns both handshakes
  cpf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // datapath: store, counters, checks and the result fields
  cpf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (item.kind),
    .rx_byte       (item.rx_byte),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.data),
    .out_byte      (result.out_byte),
    .byte_index    (result.byte_index),
    .packet_length (result.packet_length),
    .status        (result.status),
    .last          (result.last)
  );

  assign item.ready   = item_ready;
  assign result.valid = result_valid;
  // timeout register takes a write in any cycle
  assign cfg.ready    = 1'b1;

endmodule

`default_nettype wire

/* rtl/core/cpf_checker.sv */
// cpf_checker: port-level assertions for the packet framer, bound to the top level
// depends on cpf_pkg
`default_nettype none

module cpf_checker import cpf_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_valid,
  input wire logic                 item_ready,
  input wire logic                 result_valid,
  input wire logic                 result_ready,
  input wire logic [BYTE_W-1:0]    out_byte,
  input wire logic [OUT_IDX_W-1:0] byte_index,
  input wire logic [OUT_LEN_W-1:0] packet_length,
  input wire logic [STATUS_W-1:0]  status,
  input wire logic                 last
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_byte) &&
      $stable(byte_index) && $stable(packet_length) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // a rejection is a single result
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> last)
    else $error("rejection not marked last");

  // accepted packet streams without gaps, index counting up
  a_stream_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last |=>
      result_valid && byte_index == $past(byte_index) + OUT_IDX_W'(1))
    else $error("packet stream broke");

  // no new request taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("item ready during readout");

endmodule

bind controller_packet_framer_top cpf_checker u_cpf_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .out_byte      (result.out_byte),
  .byte_index    (result.byte_index),
  .packet_length (result.packet_length),
  .status        (result.status),
  .last          (result.last)
);

`default_nettype wire

/* tb/sv/cpf_frame_checker.sv */
`timescale 1ns / 100ps
// cpf_frame_checker: watches the item, result and timeout channels of the packet framer,
// predicts every result from the requests it sees and compares them in order
// depends on cpf_pkg and cpf_if

module cpf_frame_checker import cpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cpf_item_if         item,
  cpf_result_if       result,
  cpf_cfg_if          cfg,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned requests_seen,
  output int unsigned results_seen,
  output int unsigned rejects_seen
);

  typedef struct packed {
    logic [BYTE_W-1:0]    out_byte;
    logic [OUT_IDX_W-1:0] byte_index;
    logic [OUT_LEN_W-1:0] packet_length;
    logic [STATUS_W-1:0]  status;
    logic                 last;
  } frame_word_t;

  frame_word_t frames_due[$];

  // model of the open packet
  logic [BYTE_W-1:0]    held_bytes [MAX_PACKET];
  int unsigned          held_count;
  logic [BYTE_W-1:0]    held_sum;
  logic [TIMEOUT_W-1:0] quiet_ticks;
  logic [TIMEOUT_W-1:0] timeout_val;

  function automatic int unsigned framed_length(input logic [BYTE_W-1:0] t);
    case (t)
      TYPE_A, TYPE_G, TYPE_M, TYPE_L: return 15;
      TYPE_Q:                         return 19;
      TYPE_B:                         return 5;
      TYPE_C:                         return 6;
      default:                        return 0;
    endcase
  endfunction

  task automatic close_open_frame();
    logic [BYTE_W-1:0]   tail;
    logic [BYTE_W-1:0]   want_tail;
    logic [STATUS_W-1:0] verdict;
    frame_word_t         w;
    int unsigned         i;
    tail      = held_bytes[held_count - 1];
    want_tail = ~(held_sum - tail);
    if (held_bytes[0] != START_MARK) begin
      verdict = ST_NO_START;
    end else if (want_tail != tail) begin
      verdict = ST_BAD_SUM;
    end else begin
      verdict = ST_OK;
    end
    if (verdict != ST_OK) begin
      w.out_byte      = '0;
      w.byte_index    = '0;
      w.packet_length = OUT_LEN_W'(held_count);
      w.status        = verdict;
      w.last          = 1'b1;
      frames_due.push_back(w);
    end else begin
      for (i = 0; i < held_count; i++) begin
        w.out_byte      = held_bytes[i];
        w.byte_index    = OUT_IDX_W'(i);
        w.packet_length = OUT_LEN_W'(held_count);
        w.status        = ST_OK;
        w.last          = (i + 1 == held_count);
        frames_due.push_back(w);
      end
    end
    held_count  = 0;
    held_sum    = '0;
    quiet_ticks = '0;
  endtask

  task automatic take_request(input logic k, input logic [BYTE_W-1:0] b);
    int unsigned need;
    if (k == KIND_TICK) begin
      // ticks only count while a packet is open
      if (held_count != 0) begin
        if (quiet_ticks != '1) quiet_ticks++;
        if (quiet_ticks >= timeout_val) close_open_frame();
      end
    end else begin
      if (b == START_MARK) begin
        held_count = 0;
        held_sum   = '0;
      end
      held_bytes[held_count] = b;
      held_count++;
      held_sum    = held_sum + b;
      quiet_ticks = '0;
      need = (held_count >= 2) ? framed_length(held_bytes[1]) : 0;
      if (held_count >= MAX_PACKET || (need != 0 && held_count == need)) close_open_frame();
    end
  endtask

  task automatic flag_result(input string why, input frame_word_t want, input frame_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected byte %02h idx %0d len %0d status %0d last %0b", $time, why,
               want.out_byte, want.byte_index, want.packet_length, want.status, want.last);
      $display("           got      byte %02h idx %0d len %0d status %0d last %0b",
               got.out_byte, got.byte_index, got.packet_length, got.status, got.last);
    end
  endtask

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst) begin
      frames_due.delete();
      held_count    = 0;
      held_sum      = '0;
      quiet_ticks   = '0;
      timeout_val   = TIMEOUT_RESET;
      mismatches    = 0;
      requests_seen = 0;
      results_seen  = 0;
      rejects_seen  = 0;
    end else begin
      // results first, so a request taken on this edge cannot satisfy one
      if (result.valid && result.ready) begin
        results_seen++;
        got.out_byte      = result.out_byte;
        got.byte_index    = result.byte_index;
        got.packet_length = result.packet_length;
        got.status        = result.status;
        got.last          = result.last;
        if (got.status != ST_OK) rejects_seen++;
        if (frames_due.size() == 0) begin
          flag_result("unexpected result", '0, got);
        end else begin
          want = frames_due.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_index !== want.byte_index ||
              got.packet_length !== want.packet_length || got.status !== want.status ||
              got.last !== want.last) begin
            flag_result("result mismatch", want, got);
          end
        end
      end
      if (cfg.valid && cfg.ready) timeout_val = cfg.data;
      if (item.valid && item.ready) begin
        requests_seen++;
        take_request(item.kind, item.rx_byte);
      end
    end
    pending = frames_due.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stimulus, clock, reset and verdict for controller_packet_framer_top
// depends on cpf_pkg, cpf_if, cpf_frame_checker and the framer rtl

module tb_top import cpf_pkg::*;;

  // cycles with no request taken on any channel before the run is abandoned
  localparam int STALL_LIMIT   = 2000;
  // a zero-result request may still be in flight when the last result lands
  localparam int SETTLE_CYCLES = 24;
  // random requests per phase, before the closing flush packet
  localparam int PHASE_ITEMS   = 48;
  // length of the receiver hold-off that backs the framer up
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpf_item_if   item_ch ();
  cpf_result_if result_ch ();
  cpf_cfg_if    cfg_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned requests_seen;
  int unsigned results_seen;
  int unsigned rejects_seen;

  // receiver side: random stalls plus the long hold-off
  logic        sink_ready = 1'b0;
  logic        hold_off   = 1'b0;
  int unsigned stall_pct  = 0;
  // sender side: chance of a gap before each request
  int unsigned send_idle  = 0;

  int unsigned items_sent  = 0;
  logic [TIMEOUT_W-1:0] timeout_now = TIMEOUT_RESET;
  int unsigned quiet_cycles = 0;

  // packet types with a fixed length, and those lengths
  logic [BYTE_W-1:0] frame_types [0:6] = '{TYPE_A, TYPE_G, TYPE_M, TYPE_L, TYPE_Q, TYPE_B, TYPE_C};
  int unsigned       frame_lens  [0:6] = '{15, 15, 15, 15, 19, 5, 6};

  controller_packet_framer_top DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cpf_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item          (item_ch),
    .result        (result_ch),
    .cfg           (cfg_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .rejects_seen  (rejects_seen)
  );

  // 10 ns clock, high then low
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign result_ch.ready = sink_ready;

  // the receiver refuses with a chance of stall_pct percent; the hold-off overrides it
  always @(posedge clk) begin
    sink_ready <= !rst && !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog: counts cycles in which no channel moves a request
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no request moved for %0d cycles, pending results %0d", quiet_cycles, pending);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, with an optional random gap first, and wait until it is taken
  task automatic send_item(input logic k, input logic [BYTE_W-1:0] b);
    while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.kind    <= k;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // build and send one packet of len bytes; the last byte is the checksum, good or
  // deliberately wrong; payload never holds a start marker so the packet stays whole
  task automatic send_frame(input logic [BYTE_W-1:0] type_b, input int unsigned len,
                            input bit with_start, input bit good_sum,
                            input int unsigned ticks);
    logic [BYTE_W-1:0] frame [MAX_PACKET];
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] cs;
    int unsigned       i;
    do begin
      s = '0;
      for (i = 0; i + 1 < len; i++) begin
        if (i == 0 && with_start) begin
          frame[i] = START_MARK;
        end else if (i == 1) begin
          frame[i] = type_b;
        end else begin
          frame[i] = BYTE_W'($urandom_range(0, 255));
          if (frame[i] == START_MARK) frame[i] = ~frame[i];
        end
        s = s + frame[i];
      end
      cs = ~s;
    end while (good_sum && cs == START_MARK);
    // a wrong checksum that happens to be a start marker would reopen the packet
    if (!good_sum) begin
      do cs = ~s ^ BYTE_W'($urandom_range(1, 255)); while (cs == START_MARK);
    end
    for (i = 0; i + 1 < len; i++) send_item(KIND_BYTE, frame[i]);
    send_item(KIND_BYTE, cs);
    // ticks carry a random byte that the framer must ignore
    repeat (ticks) send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  // one random unit of stimulus: mostly well-formed typed packets, then untyped ones,
  // packets without a start marker, and short bursts of raw noise
  task automatic send_random_frame();
    int unsigned       pick;
    int unsigned       k;
    int unsigned       len;
    int unsigned       ticks;
    logic [BYTE_W-1:0] t;
    bit                good;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, 6);
    good = ($urandom_range(0, 9) != 0);
    // a type byte with no fixed length
    t = BYTE_W'($urandom_range(0, 255));
    if (t == START_MARK || (t >= TYPE_A && t <= TYPE_Q)) t = t ^ 8'h80;
    // short untyped packets need the timeout to close, so only while it is small
    if (timeout_now > 8 || $urandom_range(0, 2) == 0) begin
      len   = MAX_PACKET;
      ticks = 0;
    end else begin
      len   = $urandom_range(2, MAX_PACKET - 1);
      ticks = timeout_now + $urandom_range(0, 1);
    end
    if (pick < 60) begin
      send_frame(frame_types[k], frame_lens[k], 1'b1, good, 0);
    end else if (pick < 75) begin
      send_frame(t, len, 1'b1, good, ticks);
    end else if (pick < 85) begin
      if (pick[0]) send_frame(frame_types[k], frame_lens[k], 1'b0, good, 0);
      else send_frame(t, len, 1'b0, good, ticks);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_item(logic'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // drop valid, wait for every predicted result, then let trailing work drain
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    timeout_now = v;
  endtask

  // receiver held off for a counted stretch in a process of its own
  task automatic hold_receiver(input int unsigned cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // one phase: new timeout while idle, idling pattern, random traffic, then a
  // full-length packet so nothing is left open before the next register write
  task automatic run_phase(input logic [TIMEOUT_W-1:0] tmo, input int unsigned idle_pct,
                           input int unsigned stall, input bit squeeze);
    int unsigned       first;
    logic [BYTE_W-1:0] t;
    write_timeout(tmo);
    send_idle = idle_pct;
    stall_pct <= stall;
    if (squeeze) begin
      fork
        hold_receiver(HOLD_CYCLES);
      join_none
    end
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) send_random_frame();
    t = BYTE_W'($urandom_range(0, 255));
    if (t == START_MARK || (t >= TYPE_A && t <= TYPE_Q)) t = t ^ 8'h80;
    send_frame(t, MAX_PACKET, 1'b1, 1'b1, 0);
    settle();
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] last_tmo;
    item_ch.valid   <= 1'b0;
    item_ch.kind    <= KIND_BYTE;
    item_ch.rx_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases at the reset timeout of one tick
    // tick with no packet open: ignored
    send_item(KIND_TICK, 8'hFF);
    // single byte with no start marker, closed by the timeout
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_TICK, 8'h00);
    // lone start marker: checksum cannot match
    send_item(KIND_BYTE, START_MARK);
    send_item(KIND_TICK, 8'h00);
    // shortest packet that passes: marker and its inverse
    send_item(KIND_BYTE, START_MARK);
    send_item(KIND_BYTE, ~START_MARK);
    send_item(KIND_TICK, 8'h00);
    // start marker in the middle restarts the packet
    send_item(KIND_BYTE, START_MARK);
    send_item(KIND_BYTE, 8'h00);
    send_frame(TYPE_B, 5, 1'b1, 1'b1, 0);
    // type C with a broken checksum
    send_frame(TYPE_C, 6, 1'b1, 1'b0, 0);
    settle();

    // timeout extremes and a few small values, each with its own idling pattern
    run_phase(16'd1, 0, 0, 1'b0);
    run_phase(16'd3, 55, 0, 1'b0);
    run_phase(16'hFFFF, 0, 55, 1'b1);
    run_phase(16'd2, 6, 6, 1'b0);
    last_tmo = TIMEOUT_W'($urandom_range(1, 6));
    run_phase(last_tmo, 0, 0, 1'b1);

    $display("covered %0d item requests and %0d result requests, %0d of them rejections,",
             requests_seen, results_seen, rejects_seen);
    $display("over timeouts 1, 3, 65535, 2 and %0d with sender gaps, receiver stalls and hold-offs",
             last_tmo);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
